// File: hdl/kmsd_pkg.sv
// Shared types and constants of the macro stream decoder.
package kmsd_pkg;

	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP    = 3'd1;

	localparam logic [7:0] CFG_RESET [NUM_CFG] = '{
		8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7
	};

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_TYPE    = 3'd2,
		EV_DELAY   = 3'd3,
		EV_DONE    = 3'd4
	} event_kind_t;

	// One decoded word: an optional main event, an optional release of the
	// same keycode, an optional done event, emitted in that order.
	typedef struct packed {
		logic        has_main;
		event_kind_t main_kind;
		logic [15:0] value;
		logic        has_rel;
		logic        has_done;
	} kmsd_cmd_t;

endpackage

// File: hdl/kmsd_if.sv
// Handshake channels: store bytes in, decoded events out.
interface kmsd_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] macro_index;
	logic [7:0] data_byte;
	logic       end_of_store;

	modport source (output valid, start_req, macro_index, data_byte, end_of_store,
		input ready);
	modport sink (input valid, start_req, macro_index, data_byte, end_of_store,
		output ready);
endinterface

interface kmsd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [15:0] keycode;
	logic [7:0]  character;
	logic [15:0] delay_ms;
	logic        last;

	modport source (output valid, event_kind, keycode, character, delay_ms, last,
		input ready);
	modport sink (input valid, event_kind, keycode, character, delay_ms, last,
		output ready);
endinterface

// File: hdl/kmsd_front.sv
// Front end: configuration registers, playback state and byte classification.
module kmsd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [7:0]                        cfg_wdata,
	kmsd_in_if.sink                           in_ch,
	input  logic                              q_full,
	output logic                              cmd_push,
	output kmsd_pkg::kmsd_cmd_t               cmd
);
	import kmsd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SKIP, PH_READ, PH_SUB, PH_LOW, PH_HIGH
	} phase_t;

	typedef enum logic [2:0] {
		K_TAP, K_DOWN, K_UP, K_DELAY, K_XTAP, K_XDOWN, K_XUP, K_NONE
	} kclass_t;

	logic [7:0]  cfg_q [NUM_CFG];
	phase_t      phase_q, phase_n;
	logic [7:0]  skip_q, skip_n;
	logic [7:0]  sub_q, sub_n;
	logic [7:0]  low_q, low_n;
	kclass_t     kclass;
	logic        accept;
	logic        done;
	logic [15:0] kc_raw, kc;
	logic [7:0]  hi_m1, lo_m1;
	logic [15:0] ms;
	kmsd_cmd_t   cmd_n;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	// lowest matching sub-code register wins
	always_comb begin
		kclass = K_NONE;
		for (int i = 6; i >= 0; i--) begin
			if (sub_q == cfg_q[CFG_TAP + CFG_IDX_W'(i)]) kclass = kclass_t'(3'(i));
		end
	end

	assign kc_raw = {in_ch.data_byte, low_q};
	assign kc     = (kc_raw > 16'hFF00) ? {low_q, 8'h00} : kc_raw;
	assign hi_m1  = in_ch.data_byte - 8'd1;
	assign lo_m1  = low_q - 8'd1;
	// (lo-1) + (hi-1)*255 as (hi-1)*256 - (hi-1) + (lo-1)
	assign ms     = {hi_m1, 8'h00} - {8'h00, hi_m1} + {8'h00, lo_m1};

	always_comb begin
		phase_t     ph_eff;
		logic [7:0] skip_eff;
		logic [7:0] b;
		b        = in_ch.data_byte;
		ph_eff   = phase_q;
		skip_eff = skip_q;
		if (in_ch.start_req) begin
			skip_eff = in_ch.macro_index;
			ph_eff   = (in_ch.macro_index != 8'd0) ? PH_SKIP : PH_READ;
		end
		phase_n = ph_eff;
		skip_n  = skip_eff;
		sub_n   = sub_q;
		low_n   = low_q;
		done    = 1'b0;
		cmd_n   = '0;
		case (ph_eff)
			PH_SKIP: begin
				if (b == 8'd0) begin
					skip_n = skip_eff - 8'd1;
					if (skip_eff == 8'd1) phase_n = PH_READ;
				end
			end
			PH_READ: begin
				if (b == 8'd0) begin
					done = 1'b1;
				end else if (b == cfg_q[CFG_PREFIX]) begin
					phase_n = PH_SUB;
				end else begin
					cmd_n.has_main  = 1'b1;
					cmd_n.main_kind = EV_TYPE;
					cmd_n.value     = {8'h00, b};
				end
			end
			PH_SUB: begin
				if (b == 8'd0) begin
					done = 1'b1;
				end else begin
					sub_n   = b;
					phase_n = PH_LOW;
				end
			end
			PH_LOW: begin
				low_n       = b;
				phase_n     = PH_READ;
				cmd_n.value = {8'h00, b};
				case (kclass)
					K_TAP: begin
						cmd_n.has_main  = (b != 8'd0);
						cmd_n.main_kind = EV_PRESS;
						cmd_n.has_rel   = (b != 8'd0);
					end
					K_DOWN: begin
						cmd_n.has_main  = (b != 8'd0);
						cmd_n.main_kind = EV_PRESS;
					end
					K_UP: begin
						cmd_n.has_main  = (b != 8'd0);
						cmd_n.main_kind = EV_RELEASE;
					end
					K_NONE: ;
					default: phase_n = PH_HIGH;
				endcase
			end
			PH_HIGH: begin
				phase_n = PH_READ;
				if (kclass == K_DELAY) begin
					if (low_q == 8'd0 || b == 8'd0) begin
						done = 1'b1;
					end else begin
						cmd_n.has_main  = 1'b1;
						cmd_n.main_kind = EV_DELAY;
						cmd_n.value     = ms;
					end
				end else if (kc != 16'd0) begin
					cmd_n.has_main  = 1'b1;
					cmd_n.main_kind = (kclass == K_XUP) ? EV_RELEASE : EV_PRESS;
					cmd_n.value     = kc;
					cmd_n.has_rel   = (kclass == K_XTAP);
				end
			end
			default: phase_n = PH_IDLE;
		endcase
		// end of store closes any running playback
		if (!done && in_ch.end_of_store && phase_n != PH_IDLE) done = 1'b1;
		if (done) phase_n = PH_IDLE;
		cmd_n.has_done = done;
	end

	assign cmd      = cmd_n;
	assign cmd_push = accept && (cmd_n.has_main || cmd_n.has_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			skip_q  <= 8'd0;
			sub_q   <= 8'd0;
			low_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			sub_q   <= sub_n;
			low_q   <= low_n;
		end
	end

endmodule

// File: hdl/kmsd_queue.sv
// Short queue of decoded words between front and back end.
module kmsd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kmsd_pkg::kmsd_cmd_t push_cmd,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output kmsd_pkg::kmsd_cmd_t head
);
	import kmsd_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	kmsd_cmd_t    slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign full       = (count_q == (AW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)      count_q <= count_q + (AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (AW+1)'(1);
		end
	end

endmodule

// File: hdl/kmsd_back.sv
// Back end: expands each decoded word into events behind an output register.
module kmsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  kmsd_pkg::kmsd_cmd_t head,
	output logic                pop,
	kmsd_out_if.source          out_ch
);
	import kmsd_pkg::*;

	logic [2:0]  sent_q;
	logic [2:0]  pending, cur;
	logic        is_last, load;
	logic        out_valid_q;
	event_kind_t kind_q;
	logic [15:0] keycode_q, delay_q;
	logic [7:0]  char_q;
	logic        last_q;

	// bit 0 main event, bit 1 release, bit 2 done
	assign pending = {head.has_done, head.has_rel, head.has_main} & ~sent_q;
	assign cur     = {pending[2] & ~|pending[1:0], pending[1] & ~pending[0], pending[0]};
	assign is_last = ((pending & ~cur) == 3'b000);
	assign load    = head_valid && (!out_valid_q || out_ch.ready);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (load) sent_q <= is_last ? 3'b000 : (sent_q | cur);
			if (load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (cur[0]) begin
				kind_q    <= head.main_kind;
				keycode_q <= (head.main_kind inside {EV_PRESS, EV_RELEASE}) ?
					head.value : 16'd0;
				char_q    <= (head.main_kind == EV_TYPE) ? head.value[7:0] : 8'd0;
				delay_q   <= (head.main_kind == EV_DELAY) ? head.value : 16'd0;
			end else if (cur[1]) begin
				kind_q    <= EV_RELEASE;
				keycode_q <= head.value;
				char_q    <= 8'd0;
				delay_q   <= 16'd0;
			end else begin
				kind_q    <= EV_DONE;
				keycode_q <= 16'd0;
				char_q    <= 8'd0;
				delay_q   <= 16'd0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.event_kind = kind_q;
	assign out_ch.keycode    = keycode_q;
	assign out_ch.character  = char_q;
	assign out_ch.delay_ms   = delay_q;
	assign out_ch.last       = last_q;

endmodule

// File: hdl/keyboard_macro_stream_decoder_core.sv
// Macro store decoder: store bytes in, key/type/delay/done events out.
//
// in_ch carries one store byte per word, with start_req and macro_index on the
// first byte of a playback and end_of_store on the last byte of the store.
// out_ch carries the events; last marks the final event caused by one byte.
// The configuration port (cfg_we, cfg_idx, cfg_wdata) sets the prefix byte and
// the seven sub-codes; write it only while no playback events are in flight.
//
// A byte is taken every cycle while the four-word queue behind the decoder has
// room. Its first event passes through the queue and the output register to
// out_ch. The event side runs at one event per cycle while out_ch is ready, so
// a tap (press plus release) or a byte that also closes the playback holds the
// event side for each event it yields; sustained input rate is one byte per
// cycle while each byte yields at most one event and out_ch does not stall.
// When out_ch stalls the output register holds its event, the queue fills and
// in_ch.ready drops once the queue is full.
// Reset clears playback state, empties the queue and loads the default codes.
module keyboard_macro_stream_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_wdata,
	kmsd_in_if.sink                        in_ch,
	kmsd_out_if.source                     out_ch
);
	import kmsd_pkg::*;

	kmsd_cmd_t cmd, head;
	logic      cmd_push, q_full, head_valid, pop;

	kmsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	kmsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	kmsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// File: test/tb_keyboard_macro_stream_decoder_core.sv
// Testbench for the macro stream decoder: directed and random store playback against a predictor.
module tb_keyboard_macro_stream_decoder_core;
	import kmsd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_DOWN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_XTAP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_XDOWN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_XUP   = 3'd7;

	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;

	typedef enum logic [2:0] {
		DEC_IDLE, DEC_SKIP, DEC_READ, DEC_SUB, DEC_LOW, DEC_HIGH
	} dec_phase_t;

	typedef enum int {
		SC_TAP, SC_DOWN, SC_UP, SC_DELAY, SC_XTAP, SC_XDOWN, SC_XUP, SC_NONE
	} sub_class_t;

	typedef struct packed {
		event_kind_t kind;
		logic [15:0] keycode;
		logic [7:0]  character;
		logic [15:0] delay_ms;
		logic        last;
	} key_event_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [7:0] cfg_wdata;

	kmsd_in_if  in_ch ();
	kmsd_out_if out_ch ();

	keyboard_macro_stream_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// decoder copy
	dec_phase_t dec_phase;
	logic [7:0] skip_left;
	logic [7:0] sub_byte;
	logic [7:0] low_held;
	logic [7:0] code_reg [NUM_CFG];
	logic [7:0] next_codes [NUM_CFG];

	key_event_t events_due [$];
	key_event_t step_events [$];

	logic [7:0] store_q [$];
	int eos_at;
	int busy_words;
	int mismatches;
	int quiet_cycles;

	bit no_idle;
	int hold_reqs;
	int holds_seen;
	int hold_left;
	int stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'h00;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic sub_class_t classify_sub(logic [7:0] s);
		for (int i = 0; i < 7; i++)
			if (s == code_reg[i + 1])
				return sub_class_t'(i);
		return SC_NONE;
	endfunction

	function automatic void add_event(event_kind_t k, logic [15:0] kc, logic [7:0] ch,
			logic [15:0] ms);
		key_event_t e;
		e = '{k, kc, ch, ms, 1'b0};
		step_events.push_back(e);
	endfunction

	// drop zero keycodes
	function automatic void add_key(logic [15:0] kc, bit release_key);
		if (kc == 16'd0)
			return;
		if (release_key)
			add_event(EV_RELEASE, kc, 8'd0, 16'd0);
		else
			add_event(EV_PRESS, kc, 8'd0, 16'd0);
	endfunction

	// Advance the decoder copy by one store byte; returns 1 if the byte was not ignored.
	function automatic bit decode_byte(logic start, logic [7:0] idx, logic [7:0] b, logic eos);
		bit finish;
		bit busy;
		sub_class_t cls;
		logic [15:0] kc;
		int ms;
		finish = 1'b0;
		step_events.delete();
		if (start) begin
			skip_left = idx;
			dec_phase = (idx != 8'd0) ? DEC_SKIP : DEC_READ;
		end
		busy = (dec_phase != DEC_IDLE);
		case (dec_phase)
			DEC_SKIP: begin
				if (b == 8'd0) begin
					skip_left = skip_left - 8'd1;
					if (skip_left == 8'd0)
						dec_phase = DEC_READ;
				end
			end
			DEC_READ: begin
				if (b == 8'd0)
					finish = 1'b1;
				else if (b == code_reg[CFG_PREFIX])
					dec_phase = DEC_SUB;
				else
					add_event(EV_TYPE, 16'd0, b, 16'd0);
			end
			DEC_SUB: begin
				if (b == 8'd0) begin
					finish = 1'b1;
				end else begin
					sub_byte = b;
					dec_phase = DEC_LOW;
				end
			end
			DEC_LOW: begin
				cls = classify_sub(sub_byte);
				low_held = b;
				dec_phase = DEC_READ;
				case (cls)
					SC_TAP: begin
						add_key({8'd0, b}, 1'b0);
						add_key({8'd0, b}, 1'b1);
					end
					SC_DOWN: add_key({8'd0, b}, 1'b0);
					SC_UP:   add_key({8'd0, b}, 1'b1);
					SC_NONE: ;
					default: dec_phase = DEC_HIGH;
				endcase
			end
			DEC_HIGH: begin
				cls = classify_sub(sub_byte);
				dec_phase = DEC_READ;
				if (cls == SC_DELAY) begin
					if (low_held == 8'd0 || b == 8'd0) begin
						finish = 1'b1;
					end else begin
						ms = (int'(low_held) - 1) + (int'(b) - 1) * 255;
						add_event(EV_DELAY, 16'd0, 8'd0, ms[15:0]);
					end
				end else begin
					kc = {b, low_held};
					// fold keys above the 0xFF00 page onto the low byte
					if (kc > 16'hFF00)
						kc = {low_held, 8'h00};
					add_key(kc, cls == SC_XUP);
					if (cls == SC_XTAP)
						add_key(kc, 1'b1);
				end
			end
			default: dec_phase = DEC_IDLE;
		endcase
		if (!finish && eos && dec_phase != DEC_IDLE)
			finish = 1'b1;
		if (finish) begin
			add_event(EV_DONE, 16'd0, 8'd0, 16'd0);
			dec_phase = DEC_IDLE;
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i])
			events_due.push_back(step_events[i]);
		return busy;
	endfunction

	task automatic report_mismatch(input string what, input key_event_t got,
			input key_event_t want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at %0t: %s: got kind %0d key %h char %h ms %0d last %b, want kind %0d key %h char %h ms %0d last %b",
				$realtime, what, got.kind, got.keycode, got.character, got.delay_ms, got.last,
				want.kind, want.keycode, want.character, want.delay_ms, want.last);
		mismatches++;
	endtask

	task automatic send_word(input logic start, input logic [7:0] idx, input logic [7:0] data,
			input logic eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.start_req    <= start;
		in_ch.macro_index  <= idx;
		in_ch.data_byte    <= data;
		in_ch.end_of_store <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (decode_byte(start, idx, data, eos))
			busy_words++;
	endtask

	task automatic play_store(input int target);
		foreach (store_q[i])
			send_word(i == 0, (i == 0) ? 8'(target) : 8'($urandom), store_q[i], i == eos_at);
	endtask

	// Hold the input idle until every event is out and the pipeline has emptied.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_codes();
		wait_drained();
		for (int i = 0; i < NUM_CFG; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= CFG_IDX_W'(i);
			cfg_wdata <= next_codes[i];
			@(posedge clk);
			code_reg[i] = next_codes[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic play_random_macro();
		int target;
		int ending;
		store_q.delete();
		eos_at = -1;
		// deep index: the store ends while still skipping
		if ($urandom_range(0, 19) == 0) begin
			target = $urandom_range(4, 255);
			repeat ($urandom_range(1, 4)) store_q.push_back(pick_byte());
			eos_at = store_q.size() - 1;
			play_store(target);
			return;
		end
		target = $urandom_range(0, 3);
		repeat (target) begin
			repeat ($urandom_range(0, 3)) store_q.push_back(8'($urandom_range(1, 255)));
			store_q.push_back(8'h00);
		end
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
				0, 1: store_q.push_back(8'($urandom_range(1, 255)));
				2, 3: begin
					store_q.push_back(code_reg[CFG_PREFIX]);
					store_q.push_back(code_reg[$urandom_range(CFG_TAP, CFG_UP)]);
					store_q.push_back(pick_byte());
				end
				4: begin
					store_q.push_back(code_reg[CFG_PREFIX]);
					store_q.push_back(code_reg[CFG_DELAY]);
					store_q.push_back(pick_byte());
					store_q.push_back(pick_byte());
				end
				5, 6: begin
					store_q.push_back(code_reg[CFG_PREFIX]);
					store_q.push_back(code_reg[$urandom_range(CFG_XTAP, CFG_XUP)]);
					store_q.push_back(pick_byte());
					store_q.push_back($urandom_range(0, 1) ? 8'hFF : pick_byte());
				end
				7: begin
					store_q.push_back(code_reg[CFG_PREFIX]);
					store_q.push_back(8'($urandom_range(1, 255)));
					store_q.push_back(pick_byte());
				end
				default: store_q.push_back(pick_byte());
			endcase
		end
		ending = $urandom_range(0, 9);
		if (ending < 6) begin
			store_q.push_back(8'h00);
		end else if (ending == 6) begin
			eos_at = store_q.size() - 1;
		end else if (ending == 7) begin
			store_q.push_back(code_reg[CFG_PREFIX]);
			store_q.push_back(8'h00);
		end else if (ending == 9) begin
			eos_at = $urandom_range(0, store_q.size() - 1);
		end
		// otherwise leave it open: the next start abandons it
		foreach (store_q[i])
			if ($urandom_range(0, 39) == 0)
				store_q[i] = pick_byte();
		play_store(target);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				send_word(1'b0, 8'($urandom), pick_byte(), 1'($urandom));
	endtask

	task automatic run_random_macros(input int n);
		int stop;
		stop = busy_words + n;
		while (busy_words < stop) begin
			no_idle <= ($urandom_range(0, 4) == 0);
			play_random_macro();
		end
	endtask

	task automatic test_default_codes();
		logic [7:0] pf;
		pf = code_reg[CFG_PREFIX];
		send_word(1'b0, 8'hA5, 8'h5A, 1'b1);
		store_q = '{8'h41,
			pf, code_reg[CFG_TAP], 8'h04,
			pf, code_reg[CFG_UP], 8'h00,
			pf, code_reg[CFG_DELAY], 8'hFF, 8'hFF,
			pf, code_reg[CFG_DELAY], 8'h01, 8'h01,
			pf, code_reg[CFG_XTAP], 8'h34, 8'hFF,
			pf, 8'h99, 8'h07,
			pf, code_reg[CFG_DELAY], 8'h00, 8'h03};
		eos_at = -1;
		play_store(0);
		store_q = '{8'h61, 8'h00, 8'h00, 8'h62, pf, 8'h00};
		play_store(2);
		store_q = '{8'h63, pf, code_reg[CFG_DOWN]};
		play_store(0);
		store_q = '{8'h64, pf, code_reg[CFG_XUP], 8'h12, 8'h00};
		eos_at = 4;
		play_store(0);
		store_q = '{8'h65, 8'h00};
		eos_at = 1;
		play_store(0);
		store_q = '{8'h80, 8'h00};
		play_store(255);
		store_q = '{pf, code_reg[CFG_DELAY], 8'h05};
		eos_at = 2;
		play_store(0);
	endtask

	task automatic test_remapped_codes();
		next_codes = '{8'h00, 8'h09, 8'h09, 8'h09, 8'hFF, 8'h80, 8'h40, 8'h20};
		load_codes();
		store_q = '{8'h71, 8'h00};
		eos_at = -1;
		play_store(0);
		// overlapping sub-codes resolve by priority
		next_codes = '{8'hFF, 8'h09, 8'h09, 8'h0A, 8'hFF, 8'hFF, 8'h80, 8'h80};
		load_codes();
		store_q = '{code_reg[CFG_PREFIX], code_reg[CFG_DOWN], 8'h33,
			code_reg[CFG_PREFIX], code_reg[CFG_UP], 8'h44,
			code_reg[CFG_PREFIX], code_reg[CFG_XTAP], 8'h02, 8'h03,
			code_reg[CFG_PREFIX], code_reg[CFG_XUP], 8'h11, 8'h22, 8'h00};
		play_store(0);
	endtask

	task automatic test_random_default_codes();
		for (int i = 0; i < NUM_CFG; i++)
			next_codes[i] = CFG_RESET[i];
		load_codes();
		run_random_macros(65);
	endtask

	task automatic test_backpressure();
		wait_drained();
		no_idle <= 1'b1;
		hold_reqs <= hold_reqs + 1;
		repeat (6) play_random_macro();
		no_idle <= 1'b0;
	endtask

	task automatic test_random_remapped_codes();
		for (int i = 0; i < NUM_CFG; i++)
			next_codes[i] = 8'($urandom_range(1, 255));
		load_codes();
		run_random_macros(55);
	endtask

	task automatic test_random_extreme_codes();
		next_codes = '{8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F, 8'h80, 8'h02};
		load_codes();
		run_random_macros(55);
	endtask

	task automatic test_random_overlapping_codes();
		next_codes = '{8'h01, 8'h02, 8'h02, 8'h03, 8'h03, 8'h05, 8'h05, 8'h05};
		load_codes();
		run_random_macros(55);
	endtask

	// event side: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_reqs != holds_seen) begin
			holds_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		key_event_t got;
		key_event_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.kind      = event_kind_t'(out_ch.event_kind);
			got.keycode   = out_ch.keycode;
			got.character = out_ch.character;
			got.delay_ms  = out_ch.delay_ms;
			got.last      = out_ch.last;
			if (events_due.size() == 0) begin
				report_mismatch("event with nothing due", got, got);
			end else begin
				want = events_due.pop_front();
				if (got.kind !== want.kind || got.keycode !== want.keycode
						|| got.character !== want.character
						|| got.delay_ms !== want.delay_ms || got.last !== want.last)
					report_mismatch("wrong event", got, want);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = 8'd0;
		in_ch.valid = 1'b0;
		in_ch.start_req = 1'b0;
		in_ch.macro_index = 8'd0;
		in_ch.data_byte = 8'd0;
		in_ch.end_of_store = 1'b0;
		out_ch.ready = 1'b0;
		no_idle = 1'b0;
		hold_reqs = 0;
		holds_seen = 0;
		hold_left = 0;
		stall_left = 0;
		busy_words = 0;
		mismatches = 0;
		quiet_cycles = 0;
		eos_at = -1;
		dec_phase = DEC_IDLE;
		skip_left = 8'd0;
		sub_byte = 8'd0;
		low_held = 8'd0;
		for (int i = 0; i < NUM_CFG; i++)
			code_reg[i] = CFG_RESET[i];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_codes();
		test_remapped_codes();
		test_random_default_codes();
		test_backpressure();
		test_random_remapped_codes();
		test_random_extreme_codes();
		test_random_overlapping_codes();
		wait_drained();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
